FILE: rtl/rsch_pkg.sv
// Shared types, constants and helpers for the ray/sphere closest-hit unit.
package rsch_pkg;

  localparam int DEFAULT_MAX_SPHERES = 16;
  localparam int CNT_W = 5;            // sphere_count register width
  localparam int SLOT_W = 4;
  localparam int SPH_W = 127;          // center x/y/z plus radius
  localparam int DIV_W = 50;           // divider dividend / quotient width
  localparam int ROOT_W = 32;
  localparam int REM_W = 36;
  localparam int STEP_W = 6;
  localparam int DIV_STEPS = 50;
  localparam int SQRT_STEPS = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  localparam logic signed [65:0] Q_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN_W = -66'sd2147483648;

  typedef enum logic {
    ITER_DIV,
    ITER_SQRT
  } iter_mode_e;

  typedef struct packed {
    logic       start;
    iter_mode_e mode;
  } iter_req_t;

  typedef struct packed {
    logic               operation;
    logic [3:0]         slot;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } rsch_in_t;

  typedef struct packed {
    logic               hit_flag;
    logic [3:0]         hit_slot;
    logic [30:0]        hit_dist;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } rsch_out_t;

  // clamp a wide signed value into Q16.16 range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > Q_MAX_W) begin
      r = 32'sh7fff_ffff;
    end else if (x < Q_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/rsch_ram.sv
// Generic single-port-write, registered-read RAM.
module rsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rsch_mul.sv
// Shared signed multiplier with a registered product.
module rsch_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 66'(a_i) * 66'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: rtl/rsch_iter.sv
// Iterative unit: restoring divide (one quotient bit per cycle) or square root.
module rsch_iter
  import rsch_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iter_req_t         req_i,
  input  logic [63:0]       num_i,
  input  logic [30:0]       den_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  res_o
);

  iter_mode_e        mode_q;
  logic [63:0]       sh_q;
  logic [REM_W-1:0]  rem_q;
  logic [DIV_W-1:0]  q_q;
  logic [30:0]       den_q;
  logic [STEP_W-1:0] cnt_q;
  logic              run_q;
  logic              done_q;

  logic [REM_W-1:0]  r1;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // one step of the selected recurrence
  always_comb begin
    unique case (mode_q)
      ITER_DIV: begin
        r1    = {rem_q[REM_W-2:0], sh_q[63]};
        trial = {{(REM_W-31){1'b0}}, den_q};
      end
      ITER_SQRT: begin
        r1    = {rem_q[REM_W-3:0], sh_q[63:62]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, q_q[ROOT_W-1:0], 2'b01};
      end
      default: begin
        r1    = '0;
        trial = '0;
      end
    endcase
    ge = (r1 >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= ITER_DIV;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        mode_q <= req_i.mode;
        run_q  <= 1'b1;
        rem_q  <= '0;
        q_q    <= '0;
        den_q  <= den_i;
        if (req_i.mode == ITER_DIV) begin
          sh_q  <= {num_i[DIV_W-1:0], {(64-DIV_W){1'b0}}};
          cnt_q <= STEP_W'(DIV_STEPS);
        end else begin
          sh_q  <= num_i;
          cnt_q <= STEP_W'(SQRT_STEPS);
        end
      end else if (run_q) begin
        rem_q <= ge ? (r1 - trial) : r1;
        q_q   <= {q_q[DIV_W-2:0], ge};
        sh_q  <= (mode_q == ITER_DIV) ? (sh_q << 1) : (sh_q << 2);
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = q_q;

endmodule

FILE: rtl/ray_sphere_closest_hit_unit.sv
// Ray/sphere closest-hit unit: sphere table, sequencer and shared arithmetic.
//
// A load item (operation 0) writes one sphere slot in its accept cycle; busy
// stays low. A trace item (operation 1) raises busy until its single result
// appears on result_o for exactly one cycle with result_valid_o; the receiver
// cannot stall it. A trace first forms a = dir.dir, one axis at a time. Each
// tested sphere then takes a table read and multiply/accumulate steps. A
// square root follows, skipped for a negative discriminant. One or two roots
// are tried, each by a division; a root that is not positive skips its
// division. When the sphere becomes the closest hit, the hit point and normal
// are produced axis by axis (a zero normal, with no division, for a zero radius).
// The final sequencer step registers the result, which shows in the cycle
// after. A zero direction ends the trace right after the setup. The sequence
// is paced by the one shared multiplier and the bit-serial divide/sqrt unit,
// which produces one result bit per cycle. Configuration writes are taken
// only while busy is low.
module ray_sphere_closest_hit_unit
  import rsch_pkg::*;
#(
  parameter int MAX_SPHERES = DEFAULT_MAX_SPHERES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rsch_in_t         in_i,
  output logic             result_valid_o,
  output rsch_out_t        result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  localparam int AW   = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int IW   = $clog2(MAX_SPHERES + 1);
  localparam int CMPW = (IW > CNT_W) ? IW : CNT_W;
  localparam int SW   = (SLOT_W > CMPW) ? SLOT_W : CMPW;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A_MUL, ST_A_ACC, ST_SPH, ST_READ,
    ST_B_MUL, ST_B_ACC, ST_C_MUL, ST_C_ACC, ST_R_MUL, ST_R_ACC,
    ST_BB_MUL, ST_BB_ACC, ST_AC_MUL, ST_AC_ACC,
    ST_SQRT, ST_ROOT, ST_DIV_T, ST_P_MUL, ST_P_ACC, ST_DIV_N, ST_NEXT
  } state_e;

  state_e state_q;

  logic [CNT_W-1:0]   count_q;
  logic [CMPW-1:0]    n_q;
  logic [IW-1:0]      idx_q;
  logic [1:0]         k_q;
  logic               pass_q;
  logic               found_q;
  logic [30:0]        best_t_q;
  logic [3:0]         best_slot_q;
  logic signed [31:0] org_q [3];
  logic signed [31:0] dv_q  [3];
  logic signed [31:0] oc_q  [3];
  logic signed [31:0] ctr_q [3];
  logic signed [31:0] pt_q  [3];
  logic signed [31:0] nrm_q [3];
  logic [30:0]        rad_q;
  logic signed [51:0] acc_q;
  logic signed [51:0] acc2_q;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic signed [31:0] c_q;
  logic signed [65:0] d_q;
  logic [ROOT_W-1:0]  sq_q;
  logic               neg_q;
  logic               res_valid_q;
  rsch_out_t          res_q;

  iter_req_t          iter_req_q;
  logic [63:0]        iter_num_q;
  logic [30:0]        iter_den_q;
  logic               iter_done;
  logic [DIV_W-1:0]   iter_res;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] mul_sh;
  logic signed [51:0] term;

  logic               ram_we;
  logic               ram_re;
  logic [SPH_W-1:0]   ram_rdata;
  logic signed [31:0] rd_c [3];

  logic               accept;
  logic signed [65:0] d_new;
  logic signed [33:0] num;
  logic [30:0]        t_val;
  logic signed [31:0] pt_new;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic signed [31:0] n_val;
  logic               sph_end;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;

  // sphere table
  assign ram_we = accept && (in_i.operation == OP_LOAD) &&
                  (SW'(in_i.slot) < SW'(MAX_SPHERES));
  assign ram_re = (state_q == ST_SPH);

  rsch_ram #(
    .WIDTH (SPH_W),
    .DEPTH (MAX_SPHERES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.slot)),
    .wdata_i ({in_i.center_x, in_i.center_y, in_i.center_z, in_i.sphere_radius}),
    .re_i    (ram_re),
    .raddr_i (AW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  assign rd_c[0] = ram_rdata[126:95];
  assign rd_c[1] = ram_rdata[94:63];
  assign rd_c[2] = ram_rdata[62:31];

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_A_MUL: begin
        mul_a = 33'(dv_q[k_q]);
        mul_b = 33'(dv_q[k_q]);
      end
      ST_B_MUL: begin
        mul_a = 33'(oc_q[k_q]);
        mul_b = 33'(dv_q[k_q]);
      end
      ST_C_MUL: begin
        mul_a = 33'(oc_q[k_q]);
        mul_b = 33'(oc_q[k_q]);
      end
      ST_R_MUL: begin
        mul_a = $signed({2'b00, rad_q});
        mul_b = $signed({2'b00, rad_q});
      end
      ST_BB_MUL: begin
        mul_a = 33'(b_q);
        mul_b = 33'(b_q);
      end
      ST_AC_MUL: begin
        mul_a = 33'(a_q);
        mul_b = 33'(c_q);
      end
      ST_P_MUL: begin
        mul_a = 33'(dv_q[k_q]);
        mul_b = $signed({2'b00, best_t_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rsch_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // product scaled back to Q16.16, floor
  assign mul_sh = mul_p >>> 16;
  assign term   = $signed(mul_sh[51:0]);

  rsch_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req_q),
    .num_i  (iter_num_q),
    .den_i  (iter_den_q),
    .done_o (iter_done),
    .res_o  (iter_res)
  );

  // datapath helpers
  always_comb begin
    d_new    = d_q - mul_p;
    num      = (pass_q ? -(34'(b_q)) + $signed({2'b00, sq_q})
                       : -(34'(b_q)) - $signed({2'b00, sq_q}));
    t_val    = (iter_res > DIV_W'(31'h7fff_ffff)) ? 31'h7fff_ffff : iter_res[30:0];
    pt_new   = sat32(66'(org_q[k_q]) + mul_sh);
    diff     = 33'(pt_new) - 33'(ctr_q[k_q]);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    if (!neg_q) begin
      n_val = (iter_res > DIV_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                                                 : $signed(iter_res[31:0]);
    end else begin
      n_val = (iter_res > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                 : $signed(-iter_res[31:0]);
    end
    sph_end = (a_q <= 0) || (CMPW'(idx_q) >= n_q);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      iter_req_q  <= '{start: 1'b0, mode: ITER_DIV};
      found_q     <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      pass_q      <= 1'b0;
    end else begin
      res_valid_q      <= 1'b0;
      iter_req_q.start <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (in_i.operation == OP_TRACE)) begin
            org_q[0] <= in_i.origin_x;
            org_q[1] <= in_i.origin_y;
            org_q[2] <= in_i.origin_z;
            dv_q[0]  <= in_i.dir_x;
            dv_q[1]  <= in_i.dir_y;
            dv_q[2]  <= in_i.dir_z;
            n_q      <= (CMPW'(count_q) >= CMPW'(MAX_SPHERES)) ?
                        CMPW'(MAX_SPHERES) : CMPW'(count_q);
            found_q  <= 1'b0;
            idx_q    <= '0;
            k_q      <= '0;
            acc_q    <= '0;
            state_q  <= ST_A_MUL;
          end
        end
        ST_A_MUL: state_q <= ST_A_ACC;
        ST_A_ACC: begin
          acc_q <= acc_q + term;
          if (k_q == 2'd2) begin
            a_q     <= sat32(66'(acc_q + term));
            state_q <= ST_SPH;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_A_MUL;
          end
        end
        ST_SPH: begin
          if (sph_end) begin
            res_valid_q       <= 1'b1;
            res_q.hit_flag    <= found_q;
            res_q.hit_slot    <= found_q ? best_slot_q : '0;
            res_q.hit_dist    <= found_q ? best_t_q : '0;
            res_q.point_x     <= found_q ? pt_q[0] : '0;
            res_q.point_y     <= found_q ? pt_q[1] : '0;
            res_q.point_z     <= found_q ? pt_q[2] : '0;
            res_q.normal_x    <= found_q ? nrm_q[0] : '0;
            res_q.normal_y    <= found_q ? nrm_q[1] : '0;
            res_q.normal_z    <= found_q ? nrm_q[2] : '0;
            state_q           <= ST_IDLE;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          for (int j = 0; j < 3; j++) begin
            ctr_q[j] <= rd_c[j];
            oc_q[j]  <= sat32(66'(33'(org_q[j]) - 33'(rd_c[j])));
          end
          rad_q   <= ram_rdata[30:0];
          acc_q   <= '0;
          acc2_q  <= '0;
          k_q     <= '0;
          state_q <= ST_B_MUL;
        end
        ST_B_MUL: state_q <= ST_B_ACC;
        ST_B_ACC: begin
          acc_q   <= acc_q + term;
          state_q <= ST_C_MUL;
        end
        ST_C_MUL: state_q <= ST_C_ACC;
        ST_C_ACC: begin
          acc2_q <= acc2_q + term;
          if (k_q == 2'd2) begin
            state_q <= ST_R_MUL;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_B_MUL;
          end
        end
        ST_R_MUL: state_q <= ST_R_ACC;
        ST_R_ACC: begin
          b_q     <= sat32(66'(acc_q));
          c_q     <= sat32(66'(acc2_q - term));
          state_q <= ST_BB_MUL;
        end
        ST_BB_MUL: state_q <= ST_BB_ACC;
        ST_BB_ACC: begin
          d_q     <= mul_p;
          state_q <= ST_AC_MUL;
        end
        ST_AC_MUL: state_q <= ST_AC_ACC;
        ST_AC_ACC: begin
          if (d_new < 0) begin
            state_q <= ST_NEXT;
          end else begin
            iter_req_q <= '{start: 1'b1, mode: ITER_SQRT};
            iter_num_q <= d_new[63:0];
            state_q    <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (iter_done) begin
            sq_q    <= iter_res[ROOT_W-1:0];
            pass_q  <= 1'b0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (num > 0) begin
            iter_req_q <= '{start: 1'b1, mode: ITER_DIV};
            iter_num_q <= {{(64-DIV_W){1'b0}}, 1'b0, num[32:0], 16'h0000};
            iter_den_q <= a_q[30:0];
            state_q    <= ST_DIV_T;
          end else if (!pass_q) begin
            pass_q <= 1'b1;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_DIV_T: begin
          if (iter_done) begin
            if ((t_val != '0) && (!found_q || (t_val < best_t_q))) begin
              found_q     <= 1'b1;
              best_t_q    <= t_val;
              best_slot_q <= 4'(idx_q);
              k_q         <= '0;
              state_q     <= ST_P_MUL;
            end else if (!pass_q) begin
              pass_q  <= 1'b1;
              state_q <= ST_ROOT;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end
        ST_P_MUL: state_q <= ST_P_ACC;
        ST_P_ACC: begin
          pt_q[k_q] <= pt_new;
          if (rad_q == '0) begin
            nrm_q[k_q] <= '0;
            if (k_q == 2'd2) begin
              state_q <= ST_NEXT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_P_MUL;
            end
          end else begin
            neg_q      <= diff[32];
            iter_req_q <= '{start: 1'b1, mode: ITER_DIV};
            iter_num_q <= {{(64-DIV_W){1'b0}}, 1'b0, diff_mag, 16'h0000};
            iter_den_q <= rad_q;
            state_q    <= ST_DIV_N;
          end
        end
        ST_DIV_N: begin
          if (iter_done) begin
            nrm_q[k_q] <= n_val;
            if (k_q == 2'd2) begin
              state_q <= ST_NEXT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_P_MUL;
            end
          end
        end
        ST_NEXT: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= ST_SPH;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: rtl/rsch_checker.sv
// Port-level checks for the ray/sphere closest-hit unit, bound to the top.
module rsch_checker
  import rsch_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input rsch_in_t  in_i,
  input logic      result_valid_o,
  input rsch_out_t result_o,
  input logic      cfg_ready_o
);

  // a result ends the trace: unit is idle while it shows
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // one result per trace, never two in a row
  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result repeated");

  // a miss reports all-zero fields (checked on distance, point x and normal z)
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.hit_flag) |->
      (result_o.hit_dist == '0 && result_o.point_x == '0 && result_o.normal_z == '0))
    else $error("miss with nonzero fields");

  // a load item never makes the unit busy
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.operation == OP_LOAD)) |=> !busy)
    else $error("load item made unit busy");

  // config port open exactly while idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !busy)
    else $error("config ready while busy");

endmodule

bind ray_sphere_closest_hit_unit rsch_checker u_rsch_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .in_i           (in_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .cfg_ready_o    (cfg_ready_o)
);
